### rtl/mpi_pkg.sv
// ----------------------------------------------------------------------------
// mpi_pkg
// Shared widths, sequencer state codes and the hand-off type of the modular
// power / inverse core.
// ----------------------------------------------------------------------------
`default_nettype none

package mpi_pkg;

    localparam int MOD_WIDTH = 31;
    localparam int EXP_WIDTH = 32;

    // signed Bezout coefficients and partial quotient products stay within +-2*modulus
    localparam int SGN_WIDTH = MOD_WIDTH + 3;
    // width of the shift-and-subtract sum: 2*rem + bit + addend < 3*modulus
    localparam int SUM_WIDTH = MOD_WIDTH + 2;
    localparam int CNT_WIDTH = $clog2(SGN_WIDTH + 1);

    localparam int S_TDATA_WIDTH = ((MOD_WIDTH + EXP_WIDTH + MOD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((MOD_WIDTH + 7) / 8) * 8;

    localparam logic KIND_POWER   = 1'b0;
    localparam logic KIND_INVERSE = 1'b1;

    localparam int ST_WIDTH = 4;
    localparam logic [ST_WIDTH-1:0] ST_IDLE    = 4'd0;
    localparam logic [ST_WIDTH-1:0] ST_RED     = 4'd1;  // operand mod modulus
    localparam logic [ST_WIDTH-1:0] ST_PBIT    = 4'd2;  // examine next exponent bit
    localparam logic [ST_WIDTH-1:0] ST_MUL_ACC = 4'd3;  // acc = acc * base mod m
    localparam logic [ST_WIDTH-1:0] ST_MUL_SQ  = 4'd4;  // base = base * base mod m
    localparam logic [ST_WIDTH-1:0] ST_ECHK    = 4'd5;  // Euclid loop test
    localparam logic [ST_WIDTH-1:0] ST_EDIV    = 4'd6;  // Euclid quotient step
    localparam logic [ST_WIDTH-1:0] ST_FRED    = 4'd7;  // normalize coefficient
    localparam logic [ST_WIDTH-1:0] ST_DONE    = 4'd8;

    typedef struct packed {
        logic                 done;
        logic [MOD_WIDTH-1:0] result;
    } mpi_res_t;

endpackage

`default_nettype wire

### rtl/modular_power_and_inverse_core.sv
// ----------------------------------------------------------------------------
// modular_power_and_inverse_core
// Modular power (square and multiply) and modular inverse (extended Euclid).
// ----------------------------------------------------------------------------
// One request word in, one result word out. tuser selects the operation:
// 0 computes operand^exponent mod modulus, 1 returns the Bezout coefficient
// of operand for (operand, modulus) normalized into 0..modulus-1 (the inverse
// when the two are coprime). A zero exponent gives 1, a zero modulus gives 0.
// All arithmetic runs on one shift-and-subtract unit, one bit per cycle, so
// a request occupies the core until its result is handed off, with s_tready
// low meanwhile. Power: reduce the operand, then per exponent bit up to its
// highest set bit one decision step, a modular multiply of the accumulator
// where the bit is set and a modular square of the base, then one final
// decision step, the hand-off of the result and a return to idle. Inverse:
// per Euclid step a loop test and a quotient step (at most ~45 steps for
// 31-bit values), then a loop test and a normalization of the coefficient.
// The finished result sits in an output register, so a new request is
// taken while it waits for m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_power_and_inverse_core
    import mpi_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_TDATA_WIDTH-1:0] s_tdata,  // operand, exponent, modulus, zero pad
    input  wire logic [0:0]               s_tuser,  // kind
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [M_TDATA_WIDTH-1:0] m_tdata   // result, zero pad
);

    logic                 seq_idle;
    logic                 start;
    logic                 ack;
    mpi_res_t             res;
    logic                 m_valid_reg, m_valid_next;
    logic [MOD_WIDTH-1:0] m_result_reg;

    assign s_tready = seq_idle;
    assign start    = s_tvalid && seq_idle;

    mpi_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .kind     (s_tuser[0]),
        .operand  (s_tdata[MOD_WIDTH-1:0]),
        .exponent (s_tdata[MOD_WIDTH+EXP_WIDTH-1:MOD_WIDTH]),
        .modulus  (s_tdata[2*MOD_WIDTH+EXP_WIDTH-1:MOD_WIDTH+EXP_WIDTH]),
        .idle     (seq_idle),
        .res      (res),
        .ack      (ack)
    );

    // hand the result over when the output word is free or leaving
    assign ack = res.done && (!m_valid_reg || m_tready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ack) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ack) begin
            m_result_reg <= res.result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_WIDTH'(m_result_reg);

endmodule

`default_nettype wire

### rtl/mpi_step_unit.sv
// ----------------------------------------------------------------------------
// mpi_step_unit
// One shift-and-subtract step, shared by division (one quotient bit) and
// interleaved modular multiplication (one multiplier bit).
// ----------------------------------------------------------------------------
`default_nettype none

module mpi_step_unit
    import mpi_pkg::*;
(
    input  wire logic [MOD_WIDTH-1:0] rem_in,
    input  wire logic                 shift_bit,
    input  wire logic [MOD_WIDTH-1:0] addend,
    input  wire logic [MOD_WIDTH-1:0] divisor,
    output logic      [MOD_WIDTH-1:0] rem_out,
    output logic                      qbit
);

    logic [SUM_WIDTH-1:0] sum0;
    logic [SUM_WIDTH-1:0] sum1;
    logic [SUM_WIDTH-1:0] sum2;
    logic [SUM_WIDTH-1:0] div_ext;

    always_comb begin
        div_ext = SUM_WIDTH'(divisor);
        sum0    = {1'b0, rem_in, shift_bit} + SUM_WIDTH'(addend);
        qbit    = (sum0 >= div_ext);
        sum1    = qbit ? (sum0 - div_ext) : sum0;
        // second subtract only fires when an addend was folded in
        sum2    = (sum1 >= div_ext) ? (sum1 - div_ext) : sum1;
        rem_out = sum2[MOD_WIDTH-1:0];
    end

endmodule

`default_nettype wire

### rtl/mpi_seq.sv
// ----------------------------------------------------------------------------
// mpi_seq
// Sequencer and working registers: square-and-multiply exponentiation and
// extended Euclid, both driven through the shared step unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mpi_seq
    import mpi_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic                 kind,
    input  wire logic [MOD_WIDTH-1:0] operand,
    input  wire logic [EXP_WIDTH-1:0] exponent,
    input  wire logic [MOD_WIDTH-1:0] modulus,
    output logic                      idle,
    output mpi_res_t                  res,
    input  wire logic                 ack
);

    logic [ST_WIDTH-1:0]         state_reg, state_next;
    logic [CNT_WIDTH-1:0]        cnt_reg, cnt_next;
    logic [MOD_WIDTH-1:0]        mod_reg, mod_next;
    logic [EXP_WIDTH-1:0]        exp_reg, exp_next;
    logic [MOD_WIDTH-1:0]        acc_reg, acc_next;
    logic [MOD_WIDTH-1:0]        base_reg, base_next;
    logic [MOD_WIDTH-1:0]        mpl_reg, mpl_next;
    logic [MOD_WIDTH-1:0]        rem_reg, rem_next;
    logic [SGN_WIDTH-1:0]        num_reg, num_next;
    logic signed [SGN_WIDTH-1:0] prod_reg, prod_next;
    logic [MOD_WIDTH-1:0]        rp_reg, rp_next;
    logic [MOD_WIDTH-1:0]        rc_reg, rc_next;
    logic signed [SGN_WIDTH-1:0] sp_reg, sp_next;
    logic signed [SGN_WIDTH-1:0] sc_reg, sc_next;
    logic                        neg_reg, neg_next;

    logic                 su_bit;
    logic [MOD_WIDTH-1:0] su_addend;
    logic [MOD_WIDTH-1:0] su_divisor;
    logic [MOD_WIDTH-1:0] su_rem;
    logic                 su_q;
    logic                 last_step;
    logic signed [SGN_WIDTH-1:0] prod_step;

    mpi_step_unit u_step (
        .rem_in    (rem_reg),
        .shift_bit (su_bit),
        .addend    (su_addend),
        .divisor   (su_divisor),
        .rem_out   (su_rem),
        .qbit      (su_q)
    );

    // operand routing into the shared unit
    always_comb begin
        su_bit     = 1'b0;
        su_addend  = '0;
        su_divisor = mod_reg;
        unique case (state_reg)
            ST_RED, ST_FRED: begin
                su_bit = num_reg[SGN_WIDTH-1];
            end
            ST_MUL_ACC, ST_MUL_SQ: begin
                su_addend = mpl_reg[MOD_WIDTH-1] ? base_reg : '0;
            end
            ST_EDIV: begin
                su_bit     = num_reg[SGN_WIDTH-1];
                su_divisor = rc_reg;
            end
            default: begin
                su_bit = 1'b0;
            end
        endcase
    end

    assign last_step = (cnt_reg == CNT_WIDTH'(1));
    assign prod_step = (prod_reg <<< 1) + (su_q ? sc_reg : SGN_WIDTH'(0));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mod_next   = mod_reg;
        exp_next   = exp_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        mpl_next   = mpl_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        prod_next  = prod_reg;
        rp_next    = rp_reg;
        rc_next    = rc_reg;
        sp_next    = sp_reg;
        sc_next    = sc_reg;
        neg_next   = neg_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    mod_next = modulus;
                    exp_next = exponent;
                    rem_next = '0;
                    if (modulus == '0) begin
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end else if (kind == KIND_POWER) begin
                        if (exponent == '0) begin
                            acc_next   = MOD_WIDTH'(1);
                            state_next = ST_DONE;
                        end else begin
                            acc_next   = MOD_WIDTH'(1);
                            num_next   = SGN_WIDTH'(operand);
                            cnt_next   = CNT_WIDTH'(SGN_WIDTH);
                            state_next = ST_RED;
                        end
                    end else begin
                        rp_next    = operand;
                        rc_next    = modulus;
                        sp_next    = SGN_WIDTH'(1);
                        sc_next    = '0;
                        state_next = ST_ECHK;
                    end
                end
            end

            ST_RED: begin
                rem_next = su_rem;
                num_next = num_reg << 1;
                cnt_next = cnt_reg - CNT_WIDTH'(1);
                if (last_step) begin
                    base_next  = su_rem;
                    state_next = ST_PBIT;
                end
            end

            ST_PBIT: begin
                rem_next = '0;
                cnt_next = CNT_WIDTH'(MOD_WIDTH);
                if (exp_reg == '0) begin
                    state_next = ST_DONE;
                end else if (exp_reg[0]) begin
                    mpl_next   = acc_reg;
                    state_next = ST_MUL_ACC;
                end else begin
                    mpl_next   = base_reg;
                    state_next = ST_MUL_SQ;
                end
            end

            ST_MUL_ACC: begin
                rem_next = su_rem;
                mpl_next = mpl_reg << 1;
                cnt_next = cnt_reg - CNT_WIDTH'(1);
                if (last_step) begin
                    acc_next   = su_rem;
                    mpl_next   = base_reg;
                    rem_next   = '0;
                    cnt_next   = CNT_WIDTH'(MOD_WIDTH);
                    state_next = ST_MUL_SQ;
                end
            end

            ST_MUL_SQ: begin
                rem_next = su_rem;
                mpl_next = mpl_reg << 1;
                cnt_next = cnt_reg - CNT_WIDTH'(1);
                if (last_step) begin
                    base_next  = su_rem;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_PBIT;
                end
            end

            ST_ECHK: begin
                rem_next = '0;
                cnt_next = CNT_WIDTH'(SGN_WIDTH);
                if (rc_reg == '0) begin
                    neg_next   = sp_reg[SGN_WIDTH-1];
                    num_next   = sp_reg[SGN_WIDTH-1] ? SGN_WIDTH'(-sp_reg)
                                                     : SGN_WIDTH'(sp_reg);
                    state_next = ST_FRED;
                end else begin
                    num_next   = SGN_WIDTH'(rp_reg);
                    prod_next  = '0;
                    state_next = ST_EDIV;
                end
            end

            ST_EDIV: begin
                rem_next  = su_rem;
                num_next  = num_reg << 1;
                prod_next = prod_step;
                cnt_next  = cnt_reg - CNT_WIDTH'(1);
                if (last_step) begin
                    rp_next    = rc_reg;
                    rc_next    = su_rem;
                    sp_next    = sc_reg;
                    sc_next    = sp_reg - prod_step;
                    state_next = ST_ECHK;
                end
            end

            ST_FRED: begin
                rem_next = su_rem;
                num_next = num_reg << 1;
                cnt_next = cnt_reg - CNT_WIDTH'(1);
                if (last_step) begin
                    acc_next   = (neg_reg && (su_rem != '0)) ? (mod_reg - su_rem) : su_rem;
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (ack) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mod_reg  <= mod_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        mpl_reg  <= mpl_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        prod_reg <= prod_next;
        rp_reg   <= rp_next;
        rc_reg   <= rc_next;
        sp_reg   <= sp_next;
        sc_reg   <= sc_next;
        neg_reg  <= neg_next;
    end

    assign idle       = (state_reg == ST_IDLE);
    assign res.done   = (state_reg == ST_DONE);
    assign res.result = acc_reg;

endmodule

`default_nettype wire

### dv/tb_modular_power_and_inverse_core.sv
// ----------------------------------------------------------------------------
// tb_modular_power_and_inverse_core
// Drives power and inverse requests into the core over the request stream
// and predicts each result in the bench. Every returned word is compared in
// order against the oldest prediction. A short directed set covers the edge
// cases. A random set follows, run in three phases of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module tb_modular_power_and_inverse_core;
    import mpi_pkg::*;

    localparam logic [MOD_WIDTH-1:0] MOD_MAX = '1;
    localparam int RANDOM_WORDS = 268;

    // in-order predictor and checker for result words
    class mpi_scoreboard;
        logic [MOD_WIDTH-1:0] expected_results[$];
        int errors = 0;

        function automatic logic [MOD_WIDTH-1:0] power_mod(longint unsigned base,
                                                           longint unsigned ex,
                                                           longint unsigned m);
            longint unsigned acc;
            acc = 1;
            if (ex == 0) return 1;
            base = base % m;
            for (int i = 0; i < EXP_WIDTH; i++) begin
                if (ex[i]) acc = (acc * base) % m;
                base = (base * base) % m;
            end
            return MOD_WIDTH'(acc % m);
        endfunction

        function automatic logic [MOD_WIDTH-1:0] bezout_coeff(longint x, longint m);
            longint r0, r1, s0, s1, q, t, c;
            r0 = x;
            r1 = m;
            s0 = 1;
            s1 = 0;
            while (r1 != 0) begin
                q  = r0 / r1;
                t  = r0 - q * r1;
                r0 = r1;
                r1 = t;
                t  = s0 - q * s1;
                s0 = s1;
                s1 = t;
            end
            c = s0 % m;
            if (c < 0) c += m;
            return MOD_WIDTH'(c);
        endfunction

        function void note_request(logic kind, logic [MOD_WIDTH-1:0] op,
                                   logic [EXP_WIDTH-1:0] ex, logic [MOD_WIDTH-1:0] md);
            logic [MOD_WIDTH-1:0] r;
            if (md == 0)
                r = '0;
            else if (kind == KIND_POWER)
                r = power_mod(op, ex, md);
            else
                r = bezout_coeff(longint'(op), longint'(md));
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_WIDTH-1:0] word);
            logic [MOD_WIDTH-1:0] exp_r;
            if (expected_results.size() == 0) begin
                $error("result word with no request pending: result %0d",
                       word[MOD_WIDTH-1:0]);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (word[MOD_WIDTH-1:0] !== exp_r) begin
                $error("result mismatch: expected %0d, actual %0d",
                       exp_r, word[MOD_WIDTH-1:0]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata;   // operand, exponent, modulus, zero pad
    logic [0:0]               s_tuser;   // kind
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_WIDTH-1:0] m_tdata;   // result, zero pad

    int src_idle = 27;
    int dst_idle = 71;

    mpi_scoreboard sb = new();

    modular_power_and_inverse_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= dst_idle);
    end

    // request noted before result, so a result on the same edge pairs with older words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser[0], s_tdata[MOD_WIDTH-1:0],
                                s_tdata[MOD_WIDTH +: EXP_WIDTH],
                                s_tdata[MOD_WIDTH+EXP_WIDTH +: MOD_WIDTH]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    task automatic send_request(input logic kind, input logic [MOD_WIDTH-1:0] op,
                                input logic [EXP_WIDTH-1:0] ex,
                                input logic [MOD_WIDTH-1:0] md);
        logic [S_TDATA_WIDTH-1:0] word;
        word = '0;
        word[MOD_WIDTH-1:0] = op;
        word[MOD_WIDTH +: EXP_WIDTH] = ex;
        word[MOD_WIDTH+EXP_WIDTH +: MOD_WIDTH] = md;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold off the sender until every outstanding result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [EXP_WIDTH-1:0] random_exponent();
        int n;
        logic [EXP_WIDTH-1:0] e;
        e = $urandom;
        if ($urandom_range(3) == 0) return e;
        // mostly short exponents keep the run time down
        n = $urandom_range(1, EXP_WIDTH);
        return e >> (EXP_WIDTH - n);
    endfunction

    function automatic logic [MOD_WIDTH-1:0] random_modulus();
        logic [MOD_WIDTH-1:0] m;
        case ($urandom_range(9))
            0: m = MOD_WIDTH'($urandom_range(1, 16));
            1: m = MOD_MAX - MOD_WIDTH'($urandom_range(0, 15));
            default: m = MOD_WIDTH'($urandom);
        endcase
        if (m == 0) m = 1;
        return m;
    endfunction

    function automatic logic [MOD_WIDTH-1:0] random_operand();
        case ($urandom_range(9))
            0: return '0;
            1: return MOD_MAX;
            2: return MOD_WIDTH'($urandom_range(1, 64));
            default: return MOD_WIDTH'($urandom);
        endcase
    endfunction

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_POWER;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: edge values, both operations, special cases
        send_request(KIND_POWER,   31'd0,        32'd0,          31'd1);
        send_request(KIND_POWER,   MOD_MAX,      32'd0,          MOD_MAX);
        send_request(KIND_POWER,   31'd0,        32'd0,          31'd7);
        send_request(KIND_POWER,   31'd5,        32'd3,          31'd1);
        send_request(KIND_POWER,   31'd0,        32'd5,          31'd7);
        send_request(KIND_POWER,   31'd2,        32'd10,         31'd1000);
        send_request(KIND_POWER,   MOD_MAX,      32'hFFFF_FFFF,  MOD_MAX);
        send_request(KIND_POWER,   MOD_MAX,      32'hFFFF_FFFF,  31'd2147483629);
        send_request(KIND_POWER,   31'd3,        32'h8000_0000,  MOD_MAX - 31'd1);
        send_request(KIND_POWER,   31'd1,        32'd1,          31'd2);
        send_request(KIND_POWER,   31'd12345,    32'd7,          31'd0);
        send_request(KIND_INVERSE, 31'd3,        32'd0,          31'd7);
        send_request(KIND_INVERSE, 31'd0,        32'd0,          31'd7);
        send_request(KIND_INVERSE, 31'd5,        32'd9,          31'd1);
        send_request(KIND_INVERSE, 31'd6,        32'd0,          31'd9);
        send_request(KIND_INVERSE, MOD_MAX,      32'hFFFF_FFFF,  MOD_MAX);
        send_request(KIND_INVERSE, MOD_MAX,      32'd0,          31'd2);
        send_request(KIND_INVERSE, 31'd1,        32'd0,          MOD_MAX);
        send_request(KIND_INVERSE, 31'd12345,    32'd0,          31'd2147483629);
        send_request(KIND_INVERSE, MOD_MAX,      32'd0,          31'd2147483629);
        send_request(KIND_INVERSE, 31'd1346269,  32'd0,          31'd2178309);
        send_request(KIND_INVERSE, 31'd99,       32'd0,          31'd0);
        drain_results();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 3) begin
                drain_results();
                src_idle = 71;
                dst_idle = 27;
            end else if (i == 2 * RANDOM_WORDS / 3) begin
                drain_results();
                src_idle = 0;
                dst_idle = 0;
            end
            send_request(1'($urandom), random_operand(), random_exponent(),
                         random_modulus());
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
